@@ rtl/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/i2cbe_pkg.sv @@
`timescale 1ns / 1ps

package i2cbe_pkg;

  localparam int BYTE_BITS = 8;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [15:0] PHASE_TICKS_RESET = 16'd720;

  localparam logic [2:0] CMD_START    = 3'd0;
  localparam logic [2:0] CMD_STOP     = 3'd1;
  localparam logic [2:0] CMD_WRITE    = 3'd2;
  localparam logic [2:0] CMD_READ     = 3'd3;
  localparam logic [2:0] CMD_SEND_ACK = 3'd4;
  localparam logic [2:0] CMD_RECV_ACK = 3'd5;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] tx_byte;
    logic       ack_out;
    logic [7:0] target_bits;
    logic       target_ack;
  } in_word_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sample_point;
    logic [7:0] rx_byte;
    logic       ack_in;
    logic       last;
  } out_word_t;

endpackage

@@ rtl/i2c_master_bit_engine_top.sv @@
`timescale 1ns / 1ps
// I2C master bit engine.
// Input channel (in_valid/in_ready/in_word): one command word per handshake:
//   start, stop, write byte, read byte, send ack or receive ack. Unknown
//   codes are taken and dropped without any line activity.
// Output channel (out_valid/out_ready/out_word): one word per line phase with
//   SCL, open-drain SDA, the sample flag, rx_byte / ack_in and last.
// Config port (cfg_wr_en/cfg_wr_data): phase_ticks, how long each phase holds.
//   Write it only while the engine is idle. A value of 0 acts like 1.
// Phases: a command walks its phases in order (start 4, stop 3, write 24,
//   read 25, send ack 3, receive ack 4 phases), each held as phase_ticks
//   sets; the sequencer returns to idle before the next command starts.
// A two-word command queue lets the next commands in while one is on the bus.
// Reset: SCL and SDA released high, queue empty, phase_ticks back to 720.
// Receiver stall: a finished phase waits in the output register; the
//   sequencer holds the next phase until that word is taken, which
//   stretches the bus timing but loses nothing.
module i2c_master_bit_engine_top #(
  parameter int QUEUE_DEPTH = i2cbe_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  i2cbe_pkg::in_word_t  in_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output i2cbe_pkg::out_word_t out_word,
  input  logic                 cfg_wr_en,
  input  logic [15:0]          cfg_wr_data
);

  // Queue handoff between front end and sequencer
  logic                q_valid;
  logic                q_pop;
  i2cbe_pkg::in_word_t q_word;

  // Accept, drop unknown codes, queue
  i2cbe_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .q_valid  (q_valid),
    .q_word   (q_word),
    .q_pop    (q_pop)
  );

  // Walk the phases of each command, pacing them by phase_ticks
  i2cbe_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_valid     (q_valid),
    .q_word      (q_word),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_word    (out_word)
  );

endmodule

@@ rtl/i2cbe_front.sv @@
`timescale 1ns / 1ps

module i2cbe_front #(
  parameter int QUEUE_DEPTH = i2cbe_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  i2cbe_pkg::in_word_t in_word,
  output logic                q_valid,
  output i2cbe_pkg::in_word_t q_word,
  input  logic                q_pop
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  i2cbe_pkg::in_word_t mem [QUEUE_DEPTH];

  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             cmd_known;
  logic             push;
  logic             pop;

  assign in_ready  = (count_r != CNT_FULL);
  // Drop unknown command codes: they make no line activity.
  assign cmd_known = (in_word.cmd <= i2cbe_pkg::CMD_RECV_ACK);
  assign push      = in_valid && in_ready && cmd_known;
  assign q_valid   = (count_r != '0);
  assign pop       = q_pop && q_valid;
  assign q_word    = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= in_word;
    end
  end

endmodule

@@ rtl/i2cbe_back.sv @@
`timescale 1ns / 1ps

module i2cbe_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [15:0]          cfg_wr_data,
  input  logic                 q_valid,
  input  i2cbe_pkg::in_word_t  q_word,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output i2cbe_pkg::out_word_t out_word
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;
  localparam logic [2:0] BIT_LAST = 3'(i2cbe_pkg::BYTE_BITS - 1);
  localparam logic [1:0] SUB_LAST = 2'd2;

  logic                 state_r, state_nxt;
  i2cbe_pkg::in_word_t  cmd_r, cmd_nxt;
  logic [4:0]           step_r, step_nxt;
  logic [1:0]           sub_r, sub_nxt;
  logic [2:0]           bit_r, bit_nxt;
  logic [15:0]          tick_r, tick_nxt;
  logic [15:0]          ticks_r;
  logic                 scl_r, scl_nxt;
  logic                 sda_r, sda_nxt;
  logic                 out_valid_r, out_valid_nxt;
  i2cbe_pkg::out_word_t out_word_r, out_word_nxt;

  logic [15:0] ticks_m1;
  logic        tick_done;
  logic        fire;
  logic [7:0]  tx_shift;
  logic        in_byte;

  // Decoded phase
  logic       ph_set_scl, ph_scl, ph_set_sda, ph_sda;
  logic       ph_sample, ph_last, ph_ack;
  logic [7:0] ph_rx;

  assign ticks_m1  = (ticks_r == '0) ? '0 : ticks_r - 1'b1;
  assign tick_done = (tick_r >= ticks_m1);
  assign fire      = (state_r == ST_RUN) && tick_done && (!out_valid_r || out_ready);
  assign tx_shift  = cmd_r.tx_byte << bit_r;
  assign in_byte   = (cmd_r.cmd == i2cbe_pkg::CMD_WRITE) ||
                     ((cmd_r.cmd == i2cbe_pkg::CMD_READ) && (step_r != '0));
  assign q_pop     = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_comb begin
    ph_set_scl = 1'b0;
    ph_scl     = 1'b0;
    ph_set_sda = 1'b0;
    ph_sda     = 1'b0;
    ph_sample  = 1'b0;
    ph_last    = 1'b0;
    ph_ack     = 1'b0;
    ph_rx      = '0;
    case (cmd_r.cmd)
      i2cbe_pkg::CMD_START: begin
        case (step_r[1:0])
          2'd0: begin ph_set_sda = 1'b1; ph_sda = 1'b1; end
          2'd1: begin ph_set_scl = 1'b1; ph_scl = 1'b1; end
          2'd2: begin ph_set_sda = 1'b1; ph_sda = 1'b0; end
          default: begin ph_set_scl = 1'b1; ph_last = 1'b1; end
        endcase
      end
      i2cbe_pkg::CMD_STOP: begin
        case (step_r[1:0])
          2'd0: begin ph_set_sda = 1'b1; ph_sda = 1'b0; end
          2'd1: begin ph_set_scl = 1'b1; ph_scl = 1'b1; end
          default: begin ph_set_sda = 1'b1; ph_sda = 1'b1; ph_last = 1'b1; end
        endcase
      end
      i2cbe_pkg::CMD_WRITE: begin
        case (sub_r)
          2'd0: begin ph_set_sda = 1'b1; ph_sda = tx_shift[7]; end
          2'd1: begin ph_set_scl = 1'b1; ph_scl = 1'b1; end
          default: begin
            ph_set_scl = 1'b1;
            ph_last    = (bit_r == BIT_LAST);
          end
        endcase
      end
      i2cbe_pkg::CMD_READ: begin
        if (step_r == '0) begin
          ph_set_sda = 1'b1;
          ph_sda     = 1'b1;
        end else begin
          case (sub_r)
            2'd0: begin ph_set_scl = 1'b1; ph_scl = 1'b1; end
            2'd1: ph_sample = 1'b1;
            default: begin
              ph_set_scl = 1'b1;
              if (bit_r == BIT_LAST) begin
                ph_last = 1'b1;
                // Report the target's byte as given in target_bits
                ph_rx   = cmd_r.target_bits;
              end
            end
          endcase
        end
      end
      i2cbe_pkg::CMD_SEND_ACK: begin
        case (step_r[1:0])
          2'd0: begin ph_set_sda = 1'b1; ph_sda = cmd_r.ack_out; end
          2'd1: begin ph_set_scl = 1'b1; ph_scl = 1'b1; end
          default: begin ph_set_scl = 1'b1; ph_last = 1'b1; end
        endcase
      end
      i2cbe_pkg::CMD_RECV_ACK: begin
        case (step_r[1:0])
          2'd0: begin ph_set_sda = 1'b1; ph_sda = 1'b1; end
          2'd1: begin ph_set_scl = 1'b1; ph_scl = 1'b1; end
          2'd2: ph_sample = 1'b1;
          default: begin
            ph_set_scl = 1'b1;
            ph_last    = 1'b1;
            ph_ack     = cmd_r.target_ack;
          end
        endcase
      end
      default: ph_last = 1'b1;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    step_nxt      = step_r;
    sub_nxt       = sub_r;
    bit_nxt       = bit_r;
    tick_nxt      = tick_r;
    scl_nxt       = scl_r;
    sda_nxt       = sda_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          cmd_nxt   = q_word;
          step_nxt  = '0;
          sub_nxt   = '0;
          bit_nxt   = '0;
          tick_nxt  = '0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (fire) begin
          scl_nxt = ph_set_scl ? ph_scl : scl_r;
          sda_nxt = ph_set_sda ? ph_sda : sda_r;
          out_word_nxt.scl_level    = scl_nxt;
          out_word_nxt.sda_level    = sda_nxt;
          out_word_nxt.sample_point = ph_sample;
          out_word_nxt.rx_byte      = ph_rx;
          out_word_nxt.ack_in       = ph_ack;
          out_word_nxt.last         = ph_last;
          out_valid_nxt = 1'b1;
          tick_nxt      = '0;
          step_nxt      = step_r + 1'b1;
          if (in_byte) begin
            if (sub_r == SUB_LAST) begin
              sub_nxt = '0;
              bit_nxt = bit_r + 1'b1;
            end else begin
              sub_nxt = sub_r + 1'b1;
            end
          end
          if (ph_last) begin
            state_nxt = ST_IDLE;
          end
        end else if (!tick_done) begin
          tick_nxt = tick_r + 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      sub_r       <= '0;
      bit_r       <= '0;
      tick_r      <= '0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      out_valid_r <= 1'b0;
      ticks_r     <= i2cbe_pkg::PHASE_TICKS_RESET;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      sub_r       <= sub_nxt;
      bit_r       <= bit_nxt;
      tick_r      <= tick_nxt;
      scl_r       <= scl_nxt;
      sda_r       <= sda_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        ticks_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    out_word_r <= out_word_nxt;
  end

endmodule

@@ rtl/i2cbe_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module i2cbe_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_ready,
  input i2cbe_pkg::out_word_t out_word
);

  // Hold a stalled phase word
  `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_word), "stalled phase word changed")

  // Drop any pending word in reset
  `ASSERT_ALWAYS(a_rst_clear, clk, !rst_n |=> !out_valid, "output valid after reset")

  // Sample SDA only while SCL is high and SDA is released, never on a final phase
  `ASSERT_CLK(a_sample_scl, clk, rst_n, out_valid && out_word.sample_point |-> out_word.scl_level && out_word.sda_level && !out_word.last, "sample with SCL low or SDA driven")

  // Report read data only on a final phase with SCL low
  `ASSERT_CLK(a_data_last, clk, rst_n, out_valid && (out_word.ack_in || out_word.rx_byte != 8'd0) |-> out_word.last && !out_word.scl_level, "read data outside final phase")

endmodule

bind i2c_master_bit_engine_top i2cbe_checker u_chk (.*);
